// ===== sv/mwlc_pkg.sv =====
// Package for the median window calibration unit.
// Shared constants, transaction structs, config indexes and cell control.
// No dependencies.
`default_nettype none

package mwlc_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int SAMPLE_BITS  = 10;
  localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] MEDIAN_RANK = CNT_BITS'(WINDOW_DEPTH / 2);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(WINDOW_DEPTH - 1);

  localparam logic [15:0] INTERVAL_RESET = 16'd1000;
  localparam logic [31:0] SLOPE_RESET    = 32'h0001_0000;
  localparam logic [31:0] OFFSET_RESET   = 32'h0000_0000;

  typedef enum logic [1:0] {
    CFG_SAMPLE_INTERVAL = 2'd0,
    CFG_GAIN_SLOPE      = 2'd1,
    CFG_ZERO_OFFSET     = 2'd2
  } cfg_index_t;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic               sample_taken;
    logic               window_ready;
    logic               value_valid;
    logic signed [15:0] scaled_value;
  } out_t;

  typedef struct packed {
    logic load;   // copy own sample into the rotating register, clear counts
    logic rank;   // compare against passing sample and rotate
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/mwlc_cell.sv =====
// One window cell: holds a stored sample and ranks it against samples
// that rotate through the chain. Depends on mwlc_pkg.
`default_nettype none

module mwlc_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [mwlc_pkg::SAMPLE_BITS-1:0] wr_data,
  input  wire mwlc_pkg::cell_ctrl_t           ctrl,
  input  wire logic [mwlc_pkg::SAMPLE_BITS-1:0] rot_in,
  output logic      [mwlc_pkg::SAMPLE_BITS-1:0] rot_out,
  output logic      [mwlc_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                hit
);
  import mwlc_pkg::*;

  logic [CNT_BITS-1:0] below;
  logic [CNT_BITS-1:0] upto;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (wr_en) begin
      sample <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rot_out <= sample;
      below   <= '0;
      upto    <= '0;
    end else if (ctrl.rank) begin
      rot_out <= rot_in;
      if (rot_out < sample) begin
        below <= below + 1'b1;
      end
      if (rot_out <= sample) begin
        upto <= upto + 1'b1;
      end
    end
  end

  assign hit = (below <= MEDIAN_RANK) && (MEDIAN_RANK < upto);

endmodule

`default_nettype wire

// ===== sv/mwlc_scale.sv =====
// Calibration pipeline: offset + slope * median in Q16.16, truncate
// toward zero, saturate to 16 bits signed. Depends on mwlc_pkg.
`default_nettype none

module mwlc_scale (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [mwlc_pkg::SAMPLE_BITS-1:0] median,
  input  wire logic signed [31:0]               slope,
  input  wire logic signed [31:0]               offset,
  output logic                                  done,
  output logic signed [15:0]                    value
);
  import mwlc_pkg::*;

  localparam int PROD_BITS  = 32 + SAMPLE_BITS + 1;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int WHOLE_BITS = SUM_BITS - 16;

  logic [3:0]                   stage_v;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [WHOLE_BITS-1:0] whole;
  logic signed [WHOLE_BITS-1:0] whole_next;
  logic signed [15:0]           sat_next;

  always_comb begin
    whole_next = WHOLE_BITS'(sum >>> 16);
    if (sum[SUM_BITS-1] && (sum[15:0] != 16'd0)) begin
      whole_next = whole_next + WHOLE_BITS'(1);
    end
  end

  always_comb begin
    if (whole > WHOLE_BITS'(32767)) begin
      sat_next = 16'sh7FFF;
    end else if (whole < -WHOLE_BITS'(32768)) begin
      sat_next = -16'sh8000;
    end else begin
      sat_next = whole[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      stage_v <= {stage_v[2:0], start};
    end
    prod  <= slope * $signed({1'b0, median});
    sum   <= SUM_BITS'(offset) + SUM_BITS'(prod);
    whole <= whole_next;
    value <= sat_next;
  end

  assign done = stage_v[3];

endmodule

`default_nettype wire

// ===== sv/median_window_linear_calibration_unit.sv =====
// Median window with linear calibration. In a tick transaction (mode 0) the
// tick is counted, the sample may be stored, and the result is staged for the
// output register. A read transaction (mode 1) ranks the window in a chain of
// WINDOW_DEPTH cells, one rotation step per cycle; the rank rotation is
// followed by the median pick and a four-stage multiply/add/truncate/saturate
// pipeline. One transaction is in flight at a time; a new one is accepted
// while the previous result waits in the output register. Configuration
// writes are always ready. Depends on mwlc_pkg, mwlc_cell and mwlc_scale.
`default_nettype none

module median_window_linear_calibration_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mwlc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mwlc_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);
  import mwlc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_PICK,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t state;

  logic [15:0]        sample_interval;
  logic signed [31:0] gain_slope;
  logic signed [31:0] zero_offset;

  logic [SLOT_BITS-1:0] write_slot;
  logic                 ready_mark;
  logic [15:0]          elapsed_ticks;
  logic [SLOT_BITS-1:0] rank_cnt;

  logic [SAMPLE_BITS-1:0] median;
  logic                   scale_start;
  logic                   scale_done;
  logic signed [15:0]     scale_value;
  out_t                   res;

  logic accept;
  logic accept_tick;
  logic accept_read;
  logic [15:0] ticks_inc;
  logic        store;
  logic        wrap;
  cell_ctrl_t  ctrl;
  logic        out_free;

  logic [SAMPLE_BITS-1:0] rot   [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] cells [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] hits;
  logic [SAMPLE_BITS-1:0] median_next;

  assign in_stall    = (state != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = in_valid && !in_stall;
  assign accept_tick = accept && (in_data.mode == MODE_TICK);
  assign accept_read = accept && (in_data.mode == MODE_READ);
  assign ticks_inc   = (elapsed_ticks == 16'hFFFF) ? elapsed_ticks : elapsed_ticks + 16'd1;
  assign store       = ticks_inc >= sample_interval;
  assign wrap        = (write_slot == LAST_SLOT);
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    ctrl.load = accept_read;
    ctrl.rank = (state == ST_RANK);
  end

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    mwlc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (accept_tick && store && (write_slot == SLOT_BITS'(i))),
      .wr_data (in_data.adc_sample),
      .ctrl    (ctrl),
      .rot_in  (rot[(i + WINDOW_DEPTH - 1) % WINDOW_DEPTH]),
      .rot_out (rot[i]),
      .sample  (cells[i]),
      .hit     (hits[i])
    );
  end

  // all hitting cells hold the same value
  always_comb begin
    median_next = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      median_next = median_next | (hits[i] ? cells[i] : '0);
    end
  end

  mwlc_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .median (median),
    .slope  (gain_slope),
    .offset (zero_offset),
    .done   (scale_done),
    .value  (scale_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= INTERVAL_RESET;
      gain_slope      <= SLOPE_RESET;
      zero_offset     <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_INTERVAL: sample_interval <= cfg_data[15:0];
        CFG_GAIN_SLOPE:      gain_slope      <= cfg_data;
        CFG_ZERO_OFFSET:     zero_offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_slot    <= '0;
      ready_mark    <= 1'b0;
      elapsed_ticks <= '0;
      rank_cnt      <= '0;
      scale_start   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      scale_start <= 1'b0;
      if (out_valid && !out_stall && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept_tick) begin
            res.value_valid  <= 1'b0;
            res.scaled_value <= '0;
            res.sample_taken <= store;
            res.window_ready <= ready_mark || (store && wrap);
            if (store) begin
              elapsed_ticks <= '0;
              write_slot    <= wrap ? '0 : write_slot + 1'b1;
              if (wrap) begin
                ready_mark <= 1'b1;
              end
            end else begin
              elapsed_ticks <= ticks_inc;
            end
            state <= ST_EMIT;
          end else if (accept_read) begin
            res.value_valid  <= 1'b1;
            res.sample_taken <= 1'b0;
            res.window_ready <= ready_mark;
            ready_mark       <= 1'b0;
            rank_cnt         <= '0;
            state            <= ST_RANK;
          end
        end
        ST_RANK: begin
          rank_cnt <= rank_cnt + 1'b1;
          if (rank_cnt == LAST_SLOT) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: begin
          median      <= median_next;
          scale_start <= 1'b1;
          state       <= ST_SCALE;
        end
        ST_SCALE: begin
          if (scale_done) begin
            res.scaled_value <= scale_value;
            state            <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_median_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |-> ($countones(hits) >= 1))
    else $error("no cell ranks as median");

  a_store_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept_tick && store) |=> (elapsed_ticks == 16'd0))
    else $error("tick counter not restarted after store");

  a_read_clears_ready: assert property (@(posedge clk) disable iff (rst)
    accept_read |=> !ready_mark)
    else $error("ready flag not cleared by read");

  a_emit_kind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && res.value_valid) |-> !res.sample_taken)
    else $error("read result marked as stored sample");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for median_window_linear_calibration_unit: directed and random tick/read
// transactions, each checked against an in-bench window and calibration predictor.
// Depends on mwlc_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
  import mwlc_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = WINDOW_DEPTH + 16;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  median_window_linear_calibration_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [SAMPLE_BITS-1:0]  win_samples [WINDOW_DEPTH];
  logic [SLOT_BITS-1:0]    win_slot;
  logic                    win_full;
  logic [15:0]             tick_count;
  logic [15:0]             cfg_interval;
  logic signed [31:0]      cfg_slope;
  logic signed [31:0]      cfg_offset;

  out_t pending_results [$];
  int   error_count = 0;
  bit   allow_idle = 1'b0;
  int   stall_left = 0;

  function automatic out_t predict_item(input in_t item);
    out_t                   r;
    logic [SAMPLE_BITS-1:0] sorted [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] key;
    int                     j;
    longint                 acc;
    longint                 whole;
    r = '0;
    if (item.mode == MODE_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      if (tick_count >= cfg_interval) begin
        win_samples[win_slot] = item.adc_sample;
        tick_count = '0;
        r.sample_taken = 1'b1;
        if (win_slot == LAST_SLOT) win_full = 1'b1;
        win_slot++;
      end
      r.window_ready = win_full;
    end else begin
      r.window_ready = win_full;
      r.value_valid = 1'b1;
      sorted = win_samples;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        key = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > key) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = key;
      end
      acc = longint'(cfg_offset) + longint'(cfg_slope) * longint'(sorted[WINDOW_DEPTH / 2]);
      whole = acc / 65536;
      if (whole > 32767) whole = 32767;
      if (whole < -32768) whole = -32768;
      r.scaled_value = whole[15:0];
      win_full = 1'b0;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic send_item(input in_t item);
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_item(item));
  endtask

  task automatic send_tick(input logic [SAMPLE_BITS-1:0] sample);
    in_t item;
    item.mode = MODE_TICK;
    item.adc_sample = sample;
    send_item(item);
  endtask

  task automatic send_read();
    in_t item;
    item.mode = MODE_READ;
    item.adc_sample = SAMPLE_BITS'($urandom);
    send_item(item);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAMPLE_INTERVAL: cfg_interval = data[15:0];
      CFG_GAIN_SLOPE:      cfg_slope = data;
      CFG_ZERO_OFFSET:     cfg_offset = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t random_item(input int read_pct);
    in_t item;
    item.mode = ($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_TICK;
    item.adc_sample = SAMPLE_BITS'($urandom);
    return item;
  endfunction

  // output stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_data.sample_taken !== want.sample_taken ||
            out_data.window_ready !== want.window_ready ||
            out_data.value_valid  !== want.value_valid  ||
            out_data.scaled_value !== want.scaled_value)
          note_failure({$sformatf("mismatch: expected taken=%0d ready=%0d valid=%0d value=%0d,",
                                  want.sample_taken, want.window_ready, want.value_valid,
                                  want.scaled_value),
                        $sformatf(" got taken=%0d ready=%0d valid=%0d value=%0d",
                                  out_data.sample_taken, out_data.window_ready,
                                  out_data.value_valid, out_data.scaled_value)});
      end
    end
  end

  task automatic test_empty_window();
    send_read();
    wait_idle();
    write_reg(CFG_ZERO_OFFSET, 32'hFFFF_FFFF);
    send_read();
    wait_idle();
    write_reg(CFG_ZERO_OFFSET, 32'hFFFE_FFFF);
    send_read();
    send_tick(10'h3FF);
    wait_idle();
    write_reg(CFG_ZERO_OFFSET, 32'h0);
  endtask

  task automatic test_interval_lowering();
    send_tick(10'h155);
    send_tick(10'h0AA);
    wait_idle();
    write_reg(CFG_SAMPLE_INTERVAL, 32'd2);
    send_tick(10'h3FF);
    wait_idle();
    write_reg(CFG_UNUSED, 32'd5);
    send_tick(10'h123);
    send_tick(10'h2AA);
  endtask

  task automatic test_full_window();
    logic [SAMPLE_BITS-1:0] fill [14] = '{10'd0, 10'd1023, 10'd512, 10'd511, 10'd1, 10'd1022,
                                          10'd341, 10'd682, 10'd7, 10'd1000, 10'd100, 10'd900,
                                          10'd64, 10'd960};
    wait_idle();
    write_reg(CFG_SAMPLE_INTERVAL, 32'd0);
    foreach (fill[i]) send_tick(fill[i]);
    send_read();
    wait_idle();
    write_reg(CFG_GAIN_SLOPE, 32'h7FFF_FFFF);
    send_read();
    wait_idle();
    write_reg(CFG_GAIN_SLOPE, 32'h8000_0000);
    send_read();
  endtask

  task automatic test_random_traffic();
    int read_pct;
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      allow_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_SAMPLE_INTERVAL, 32'd0);
        1, 2:    write_reg(CFG_SAMPLE_INTERVAL, $urandom_range(1, 3));
        3:       write_reg(CFG_SAMPLE_INTERVAL, $urandom_range(4, 12));
        4:       write_reg(CFG_SAMPLE_INTERVAL, $urandom);
        default: write_reg(CFG_SAMPLE_INTERVAL, 32'h0000_FFFF);
      endcase
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_GAIN_SLOPE, $urandom);
        1:       write_reg(CFG_GAIN_SLOPE, $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        2:       write_reg(CFG_GAIN_SLOPE, 32'h7FFF_FFFF);
        3:       write_reg(CFG_GAIN_SLOPE, 32'h8000_0000);
        default: write_reg(CFG_GAIN_SLOPE, SLOPE_RESET);
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_ZERO_OFFSET, $urandom);
        1:       write_reg(CFG_ZERO_OFFSET, $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
        2:       write_reg(CFG_ZERO_OFFSET, 32'h8000_0000);
        default: write_reg(CFG_ZERO_OFFSET, OFFSET_RESET);
      endcase
      read_pct = $urandom_range(5, 30);
      repeat (100) send_item(random_item(read_pct));
    end
  endtask

  task automatic test_steady_stream();
    wait_idle();
    allow_idle = 1'b0;
    write_reg(CFG_SAMPLE_INTERVAL, 32'd1);
    write_reg(CFG_GAIN_SLOPE, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    write_reg(CFG_ZERO_OFFSET, $urandom);
    repeat (200) send_item(random_item(15));
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cfg_interval = INTERVAL_RESET;
    cfg_slope    = SLOPE_RESET;
    cfg_offset   = OFFSET_RESET;
    win_slot     = '0;
    win_full     = 1'b0;
    tick_count   = '0;
    foreach (win_samples[i]) win_samples[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    allow_idle = 1'b1;

    test_empty_window();
    test_interval_lowering();
    test_full_window();
    test_random_traffic();
    test_steady_stream();

    wait_idle();
    if (pending_results.size() != 0) note_failure("expected results left over");
    if (error_count == 0) begin
      $display("[median_window_linear_calibration_unit] OK");
    end else begin
      $display("[median_window_linear_calibration_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[median_window_linear_calibration_unit] ERROR");
    $finish;
  end

endmodule
